### design/tdt_pkg.sv
// Shared constants, types and helpers for the task delay timer table.
package tdt_pkg;

	// Table size
	localparam int NUM_TASKS = 16;
	localparam int SLOT_W    = $clog2(NUM_TASKS);
	localparam int RANK_W    = SLOT_W;
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	// Field widths
	localparam int TID_W      = 4;
	localparam int AMT_W      = 32;
	localparam int PART_W     = 8;
	localparam int TPS_W      = 14;
	localparam int KIND_W     = 3;
	localparam int OSLOT_W    = 4;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 8;

	// Conversion constants
	localparam int MS_PER_S   = 1000;
	localparam int S_PER_HOUR = 3600;
	localparam int S_PER_MIN  = 60;
	localparam int MAX_PART   = 59;
	localparam int TOT_W      = 20;              // h:m:s total in seconds, 921599 max
	localparam int PROD_W     = 48;              // delay times tick rate, three 16-bit digits
	localparam int REM_W      = 10;              // remainder of a divide by 1000

	// Divide by 1000 a 16-bit digit at a time: v / 1000 = (v >> 3) / 125,
	// and (v >> 3) / 125 = ((v >> 3) * RECIP_125) >> RECIP_SH for v < 2^26
	localparam int DIGIT_W    = 16;
	localparam int DIV_STEPS  = PROD_W / DIGIT_W;
	localparam int DIV_PRE_SH = 3;
	localparam int RECIP_125  = 8589935;         // ceil(2^30 / 125)
	localparam int RECIP_SH   = 30;
	localparam int DIV_MUL_W  = 47;              // 23-bit operand times 24-bit reciprocal
	localparam int DIV_CNT_W  = $clog2(2 * DIV_STEPS);

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

	// Input tdata layout
	localparam int TID_LSB = 0;
	localparam int AMT_LSB = TID_LSB + TID_W;
	localparam int HRS_LSB = AMT_LSB + AMT_W;
	localparam int MIN_LSB = HRS_LSB + PART_W;
	localparam int SEC_LSB = MIN_LSB + PART_W;

	typedef enum logic [1:0] {
		MODE_MS   = 2'd0,
		MODE_S    = 2'd1,
		MODE_HMS  = 2'd2,
		MODE_TICK = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		EV_BLOCKED    = 3'd0,
		EV_ZERO_DELAY = 3'd1,
		EV_HMS_ZERO   = 3'd2,
		EV_BAD_MIN    = 3'd3,
		EV_BAD_SEC    = 3'd4,
		EV_RELEASED   = 3'd5,
		EV_NO_RELEASE = 3'd6
	} ev_kind_t;

	typedef enum logic [1:0] {
		SEL_REQ   = 2'd0,
		SEL_FOUND = 2'd1,
		SEL_ZERO  = 2'd2
	} slot_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic              latch;
		logic              calc_total;
		logic              mul;
		logic              div_est;
		logic              div_step;
		logic              sweep;
		logic              block;
		logic              unblock;
		logic              out_load;
		ev_kind_t          out_kind;
		logic              out_last;
		slot_sel_t         out_sel;
		logic [SLOT_W-1:0] idx;
		logic [RANK_W-1:0] scan;
	} tdt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		mode_t            mode;
		logic             hms_zero;
		logic             bad_min;
		logic             bad_sec;
		logic             ticks_zero;
		logic             fire_now;
		logic             found;
		logic [CNT_W-1:0] count;
		logic             out_free;
	} tdt_sts_t;

	// Task id to slot, wrapped at the table size
	function automatic logic [SLOT_W-1:0] slot_of(input logic [TID_W-1:0] id);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = 0; i < 2 ** TID_W; i++) begin
			if (id == TID_W'(i))
				r = SLOT_W'(i % NUM_TASKS);
		end
		return r;
	endfunction

endpackage

### design/tdt_dp.sv
// Datapath: tick conversion, divide by 1000, slot timer table and result register.
module tdt_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tdt_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                     s_tuser,
	input  logic                           cfg_valid,
	input  logic [tdt_pkg::TPS_W-1:0]      cfg_data,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [tdt_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [tdt_pkg::KIND_W-1:0]     m_tuser,
	output logic                           m_tlast,
	input  tdt_pkg::tdt_cmd_t              cmd,
	output tdt_pkg::tdt_sts_t              sts
);
	import tdt_pkg::*;

	// Request fields
	mode_t              mode_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [AMT_W-1:0]   amount_q;
	logic [PART_W-1:0]  hours_q;
	logic [PART_W-1:0]  min_q;
	logic [PART_W-1:0]  sec_q;
	logic [TPS_W-1:0]   tps_q;

	// Conversion
	logic [TOT_W-1:0]   tot_q;
	logic [TOT_W-1:0]   tot_next;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  product;
	logic [AMT_W-1:0]   mul_a;
	logic [REM_W-1:0]   div_rem_q;
	logic [REM_W+DIGIT_W-1:0] div_v;
	logic [DIV_MUL_W-1:0] div_prod;
	logic [DIGIT_W-1:0] digit_q;
	logic [AMT_W-1:0]   ticks_val;

	// Slot table
	logic [AMT_W-1:0]   ticks_q [NUM_TASKS];
	logic [RANK_W-1:0]  rank_q  [NUM_TASKS];
	logic [NUM_TASKS-1:0] blocked_q;
	logic [NUM_TASKS-1:0] fired_q;
	logic [CNT_W-1:0]   count_q;
	logic [AMT_W-1:0]   cur_ticks;
	logic               cur_blk;
	logic               fire_now;
	logic [RANK_W-1:0]  req_rank;
	logic               req_blk;
	logic [NUM_TASKS-1:0] hit;
	logic [SLOT_W-1:0]  found_slot;

	// Result register
	logic                    ovalid_q;
	ev_kind_t                okind_q;
	logic [OSLOT_W-1:0]      oslot_q;
	logic                    olast_q;
	logic [SLOT_W-1:0]       out_slot;
	logic [SLOT_W+OSLOT_W-1:0] out_slot_ext;

	// Tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid) begin
			tps_q <= cfg_data;
		end
	end

	// Conversion arithmetic
	assign tot_next = TOT_W'(hours_q) * TOT_W'(S_PER_HOUR)
		+ TOT_W'(min_q) * TOT_W'(S_PER_MIN) + TOT_W'(sec_q);
	assign mul_a    = (mode_q == MODE_HMS) ? AMT_W'(tot_q) : amount_q;
	assign product  = PROD_W'(mul_a) * PROD_W'(tps_q);
	assign ticks_val = (|prod_q[PROD_W-1:AMT_W]) ? '1 : prod_q[AMT_W-1:0];

	// Partial remainder joined with the next digit, and its quotient by reciprocal
	assign div_v    = {div_rem_q, prod_q[PROD_W-1 -: DIGIT_W]};
	assign div_prod = DIV_MUL_W'(div_v[REM_W+DIGIT_W-1:DIV_PRE_SH]) * DIV_MUL_W'(RECIP_125);

	// Request latch, multiply and digit-wise divide by 1000 (quotient shifts into prod_q)
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q   <= mode_t'(s_tuser);
			slot_q   <= slot_of(s_tdata[TID_LSB +: TID_W]);
			amount_q <= s_tdata[AMT_LSB +: AMT_W];
			hours_q  <= s_tdata[HRS_LSB +: PART_W];
			min_q    <= s_tdata[MIN_LSB +: PART_W];
			sec_q    <= s_tdata[SEC_LSB +: PART_W];
		end
		if (cmd.calc_total)
			tot_q <= tot_next;
		if (cmd.div_est)
			digit_q <= div_prod[RECIP_SH +: DIGIT_W];
		if (cmd.mul) begin
			prod_q    <= product;
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			prod_q    <= {prod_q[PROD_W-DIGIT_W-1:0], digit_q};
			div_rem_q <= REM_W'(div_v - (REM_W+DIGIT_W)'(digit_q)
				* (REM_W+DIGIT_W)'(MS_PER_S));
		end
	end

	// Table reads
	assign cur_ticks = ticks_q[cmd.idx];
	assign cur_blk   = blocked_q[cmd.idx];
	assign fire_now  = cur_blk && (cur_ticks == AMT_W'(1));
	assign req_rank  = rank_q[slot_q];
	assign req_blk   = blocked_q[slot_q];

	// Fired slot holding the scanned rank
	always_comb begin
		found_slot = '0;
		for (int j = 0; j < NUM_TASKS; j++) begin
			hit[j] = fired_q[j] && blocked_q[j] && (rank_q[j] == cmd.scan);
			if (hit[j])
				found_slot = SLOT_W'(j);
		end
	end

	// Block state, order ranks and fired marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= '0;
			fired_q   <= '0;
			count_q   <= '0;
			for (int j = 0; j < NUM_TASKS; j++)
				rank_q[j] <= '0;
		end else begin
			if (cmd.sweep)
				fired_q[cmd.idx] <= fire_now;
			if (cmd.block) begin
				// a re-blocked slot leaves its place in the order first
				for (int j = 0; j < NUM_TASKS; j++) begin
					if (req_blk && blocked_q[j] && (rank_q[j] > req_rank))
						rank_q[j] <= rank_q[j] - 1'b1;
				end
				rank_q[slot_q]    <= req_blk ? RANK_W'(count_q - 1'b1) : RANK_W'(count_q);
				blocked_q[slot_q] <= 1'b1;
				if (!req_blk)
					count_q <= count_q + 1'b1;
			end
			if (cmd.unblock) begin
				for (int j = 0; j < NUM_TASKS; j++) begin
					if (blocked_q[j] && (rank_q[j] > cmd.scan))
						rank_q[j] <= rank_q[j] - 1'b1;
				end
				rank_q[found_slot]    <= '0;
				blocked_q[found_slot] <= 1'b0;
				fired_q[found_slot]   <= 1'b0;
				count_q               <= count_q - 1'b1;
			end
		end
	end

	// Remaining tick counts
	always_ff @(posedge clk) begin
		if (cmd.sweep && cur_blk && (cur_ticks != '0))
			ticks_q[cmd.idx] <= cur_ticks - 1'b1;
		if (cmd.block)
			ticks_q[slot_q] <= ticks_val;
	end

	// Result slot select
	always_comb begin
		unique case (cmd.out_sel)
			SEL_REQ:   out_slot = slot_q;
			SEL_FOUND: out_slot = found_slot;
			SEL_ZERO:  out_slot = '0;
			default:   out_slot = '0;
		endcase
	end
	assign out_slot_ext = {{OSLOT_W{1'b0}}, out_slot};

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			okind_q <= cmd.out_kind;
			oslot_q <= out_slot_ext[OSLOT_W-1:0];
			olast_q <= cmd.out_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OUT_DATA_W-OSLOT_W){1'b0}}, oslot_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	// Status
	assign sts.mode       = mode_q;
	assign sts.hms_zero   = (hours_q == '0) && (min_q == '0) && (sec_q == '0);
	assign sts.bad_min    = (min_q > PART_W'(MAX_PART));
	assign sts.bad_sec    = (sec_q > PART_W'(MAX_PART));
	assign sts.ticks_zero = (ticks_val == '0);
	assign sts.fire_now   = fire_now;
	assign sts.found      = |hit;
	assign sts.count      = count_q;
	assign sts.out_free   = !ovalid_q || m_tready;

endmodule

### design/tdt_ctrl.sv
// Controller: sequences conversion, divide, tick sweep and release scan.
module tdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        s_tuser,
	output logic              s_tready,
	output tdt_pkg::tdt_cmd_t cmd,
	input  tdt_pkg::tdt_sts_t sts
);
	import tdt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_SWEEP,
		ST_NONE,
		ST_SCAN
	} state_t;

	state_t               state_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [RANK_W-1:0]    scan_q;
	logic [CNT_W-1:0]     nfire_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 accept;
	logic                 hms_err;

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign s_tready = (state_q == ST_IDLE);
	assign hms_err  = sts.hms_zero || sts.bad_min || sts.bad_sec;

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.scan     = scan_q;
		cmd.out_kind = EV_BLOCKED;
		cmd.out_sel  = SEL_REQ;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = accept;
			end
			ST_CHECK: begin
				cmd.calc_total = 1'b1;
				if (hms_err && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					priority if (sts.hms_zero)
						cmd.out_kind = EV_HMS_ZERO;
					else if (sts.bad_min)
						cmd.out_kind = EV_BAD_MIN;
					else
						cmd.out_kind = EV_BAD_SEC;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIV: begin
				// even count: estimate the digit, odd count: shift it in
				cmd.div_est  = !div_cnt_q[0];
				cmd.div_step = div_cnt_q[0];
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_kind = sts.ticks_zero ? EV_ZERO_DELAY : EV_BLOCKED;
					cmd.block    = !sts.ticks_zero;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
			end
			ST_NONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_kind = EV_NO_RELEASE;
					cmd.out_sel  = SEL_ZERO;
				end
			end
			ST_SCAN: begin
				if (sts.found && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (nfire_q == CNT_W'(1));
					cmd.out_kind = EV_RELEASED;
					cmd.out_sel  = SEL_FOUND;
					cmd.unblock  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			scan_q    <= '0;
			nfire_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode_t'(s_tuser))
							MODE_TICK: begin
								state_q <= ST_SWEEP;
								idx_q   <= '0;
								nfire_q <= '0;
							end
							MODE_HMS: state_q <= ST_CHECK;
							default:  state_q <= ST_MUL;
						endcase
					end
				end
				ST_CHECK: begin
					if (!hms_err)
						state_q <= ST_MUL;
					else if (sts.out_free)
						state_q <= ST_IDLE;
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= (sts.mode == MODE_MS) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(2 * DIV_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					nfire_q <= nfire_q + CNT_W'(sts.fire_now);
					idx_q   <= idx_q + 1'b1;
					if (idx_q == SLOT_W'(NUM_TASKS - 1)) begin
						scan_q  <= RANK_W'(sts.count - 1'b1);
						state_q <= ((nfire_q == '0) && !sts.fire_now) ? ST_NONE : ST_SCAN;
					end
				end
				ST_NONE: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// walk ranks from newest to oldest; all fired slots sit below count
					if (!sts.found) begin
						scan_q <= scan_q - 1'b1;
					end else if (sts.out_free) begin
						nfire_q <= nfire_q - 1'b1;
						scan_q  <= scan_q - 1'b1;
						if (nfire_q == CNT_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/task_delay_timer_table_top.sv
// Top level of the task delay timer table: controller, datapath and checks.
//
// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   tuser=mode, tdata=task_id,amount,hours,minutes,seconds
// m_*       out  m_tvalid/m_tready   tuser=event_kind, tdata=task_slot, tlast=last
// cfg_*     in   cfg_valid/cfg_ready ticks_per_second
//
// Between accepted requests, an h:m:s delay is checked first (a rejected one ends there) and
// an ms delay goes through a three-digit divide by 1000, estimating then shifting in each digit.
// A tick sweeps all NUM_TASKS slots, then either reports no release or scans ranks from the
// newest down to the oldest fired slot (at most NUM_TASKS ranks).
// The sequence stalls only while the result register is full and m_tready is low.
// Reset clears the block flags, ranks, count and result valid; tick rate returns to 1000.
// The result register lets the next request be taken while the last result waits.
module task_delay_timer_table_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [3:0] task_id, [35:4] amount, [43:36] hours, [51:44] minutes_part,
	// [59:52] seconds_part, [63:60] zero
	input  logic [tdt_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [3:0] task_slot, [7:4] zero
	output logic [tdt_pkg::OUT_DATA_W-1:0] m_tdata,
	// [2:0] event_kind
	output logic [tdt_pkg::KIND_W-1:0]     m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tdt_pkg::TPS_W-1:0]      cfg_data
);
	import tdt_pkg::*;

	tdt_cmd_t cmd;
	tdt_sts_t sts;

	assign cfg_ready = 1'b1;

	tdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tdt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	// A result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending result");

	// Each release removes exactly one slot from the blocked count
	a_release_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unblock |=> sts.count == $past(sts.count) - 1'b1)
		else $error("blocked count not reduced by release");

	// A fired slot can only be found while something is blocked
	a_found_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		sts.found |-> sts.count != '0)
		else $error("fired slot found with empty table");

	// Blocking and releasing are never commanded together
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.block |-> !cmd.unblock && !cmd.sweep)
		else $error("conflicting table commands");
`endif

endmodule

### test/testbench.sv
// Self-checking bench for the task delay timer table: stream driver, monitor and predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tdt_pkg::*;

	typedef struct {
		mode_t       mode;
		logic [3:0]  task_id;
		logic [31:0] amount;
		logic [7:0]  hours;
		logic [7:0]  minutes;
		logic [7:0]  seconds;
		int          gap;
		bit          wait_drain;
	} request_t;

	typedef struct {
		ev_kind_t   kind;
		logic [3:0] slot;
		logic       last;
	} event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [TPS_W-1:0]      cfg_data = '0;

	// Timer table as the bench sees it
	logic [31:0]      ticks_left [16] = '{default: '0};
	bit               is_blocked [16] = '{default: 1'b0};
	int               order_rank [16] = '{default: 0};
	int               n_blocked = 0;
	logic [TPS_W-1:0] tick_rate = TPS_RESET;

	request_t pending_requests [$];
	event_t   events_due [$];
	request_t cur_request;
	bit       request_loaded = 1'b0;
	int       gap_left = 0;
	bit       hold_req = 1'b0;
	int       errors = 0;

	task_delay_timer_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void expect_event(ev_kind_t k, logic [3:0] s, logic l);
		events_due.push_back('{kind: k, slot: s, last: l});
	endfunction

	// Take a slot out of the blocked order, closing the rank gap
	function automatic void unblock_slot(int s);
		if (!is_blocked[s])
			return;
		for (int i = 0; i < 16; i++) begin
			if (is_blocked[i] && order_rank[i] > order_rank[s])
				order_rank[i]--;
		end
		is_blocked[s] = 1'b0;
		order_rank[s] = 0;
		ticks_left[s] = '0;
		if (n_blocked > 0)
			n_blocked--;
	endfunction

	// Update the table for one accepted request and queue the events it causes
	function automatic void predict_request(request_t rq);
		logic [63:0] prod;
		logic [31:0] ticks;
		bit          fired [16];
		int          released [$];
		int          total;
		int          slot;
		slot = int'(rq.task_id);
		if (rq.mode == MODE_TICK) begin
			for (int i = 0; i < 16; i++) begin
				fired[i] = 1'b0;
				if (is_blocked[i] && ticks_left[i] != 0) begin
					ticks_left[i]--;
					fired[i] = (ticks_left[i] == 0);
				end
			end
			// newest blocked slot is released first
			for (int r = n_blocked; r > 0; r--) begin
				for (int i = 0; i < 16; i++) begin
					if (fired[i] && order_rank[i] == r - 1)
						released.push_back(i);
				end
			end
			for (int i = 0; i < 16; i++) begin
				if (fired[i])
					unblock_slot(i);
			end
			if (released.size() == 0)
				expect_event(EV_NO_RELEASE, 4'd0, 1'b1);
			foreach (released[j])
				expect_event(EV_RELEASED, 4'(released[j]), j == released.size() - 1);
			return;
		end
		if (rq.mode == MODE_MS) begin
			prod = (64'(rq.amount) * 64'(tick_rate)) / 64'(MS_PER_S);
		end else if (rq.mode == MODE_S) begin
			prod = 64'(rq.amount) * 64'(tick_rate);
		end else begin
			if (rq.hours == 0 && rq.minutes == 0 && rq.seconds == 0) begin
				expect_event(EV_HMS_ZERO, rq.task_id, 1'b1);
				return;
			end
			if (rq.minutes > MAX_PART) begin
				expect_event(EV_BAD_MIN, rq.task_id, 1'b1);
				return;
			end
			if (rq.seconds > MAX_PART) begin
				expect_event(EV_BAD_SEC, rq.task_id, 1'b1);
				return;
			end
			total = int'(rq.hours) * S_PER_HOUR + int'(rq.minutes) * S_PER_MIN
				+ int'(rq.seconds);
			prod = 64'(total) * 64'(tick_rate);
		end
		ticks = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		if (ticks == 0) begin
			expect_event(EV_ZERO_DELAY, rq.task_id, 1'b1);
			return;
		end
		unblock_slot(slot);
		ticks_left[slot] = ticks;
		is_blocked[slot] = 1'b1;
		order_rank[slot] = n_blocked;
		n_blocked++;
		expect_event(EV_BLOCKED, rq.task_id, 1'b1);
	endfunction

	function automatic int idle_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
	endfunction

	function automatic void add_request(mode_t md, logic [3:0] id, logic [31:0] amt,
			logic [7:0] h, logic [7:0] m, logic [7:0] s, bit drain);
		pending_requests.push_back('{mode: md, task_id: id, amount: amt, hours: h,
			minutes: m, seconds: s, gap: idle_gap(), wait_drain: drain});
	endfunction

	// Mostly short delays and ticks so slots really expire; some raw fields
	function automatic request_t rand_request(int rate);
		request_t rq;
		int       pick;
		int       t;
		rq.task_id = 4'($urandom_range(0, 15));
		rq.amount = $urandom;
		rq.hours = 8'($urandom_range(0, 255));
		rq.minutes = 8'($urandom_range(0, 255));
		rq.seconds = 8'($urandom_range(0, 255));
		rq.gap = idle_gap();
		rq.wait_drain = ($urandom_range(0, 99) < 3);
		pick = int'($urandom_range(0, 99));
		t = int'($urandom_range(0, 6));
		if (pick < 45) begin
			rq.mode = MODE_TICK;
		end else if (pick < 85) begin
			rq.mode = mode_t'($urandom_range(0, 2));
			case (rq.mode)
			MODE_MS: begin
				rq.amount = 32'((t * MS_PER_S + rate - 1) / rate);
			end
			MODE_S: begin
				rq.amount = 32'((rate <= 6) ? t / rate : (t % 2));
			end
			default: begin
				rq.hours = '0;
				rq.minutes = '0;
				rq.seconds = 8'((rate <= 6) ? t / rate : (t % 2));
			end
			endcase
		end else begin
			rq.mode = mode_t'($urandom_range(0, 2));
			if ($urandom_range(0, 1) == 1)
				rq.minutes = 8'($urandom_range(0, 62));
			if ($urandom_range(0, 1) == 1)
				rq.seconds = 8'($urandom_range(0, 62));
			if ($urandom_range(0, 3) == 0)
				rq.hours = '0;
		end
		return rq;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_request(cur_request);
				nxt_valid = 1'b0;
				request_loaded = 1'b0;
			end
			if (!nxt_valid) begin
				if (!request_loaded && pending_requests.size() != 0) begin
					cur_request = pending_requests.pop_front();
					gap_left = cur_request.gap;
					request_loaded = 1'b1;
				end
				if (request_loaded) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (!cur_request.wait_drain || events_due.size() == 0) begin
						s_tdata <= {4'b0, cur_request.seconds, cur_request.minutes,
							cur_request.hours, cur_request.amount, cur_request.task_id};
						s_tuser <= cur_request.mode;
						nxt_valid = 1'b1;
					end
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	// Event monitor with random back-pressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin : watch_events
		event_t want;
		int     stall_left;
		int     hold_left;
		int     events_seen;
		bit     hold_done;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			events_seen = 0;
			hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (events_due.size() == 0) begin
					$display("%0t unexpected event: kind %0d slot %0d last %0d",
						$time, m_tuser, m_tdata[3:0], m_tlast);
					errors++;
				end else begin
					want = events_due.pop_front();
					if (m_tuser !== want.kind) begin
						$display("%0t event_kind: expected %0d actual %0d",
							$time, want.kind, m_tuser);
						errors++;
					end
					if (m_tdata[3:0] !== want.slot) begin
						$display("%0t task_slot: expected %0d actual %0d",
							$time, want.slot, m_tdata[3:0]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t last: expected %0d actual %0d",
							$time, want.last, m_tlast);
						errors++;
					end
				end
				events_seen++;
				stall_left = ((events_seen / 24) % 3 == 1) ? 0 : int'($urandom_range(0, 13));
			end
			if (hold_req && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic wait_idle();
		while (pending_requests.size() != 0 || request_loaded || s_tvalid ||
				events_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_rate(input logic [TPS_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tick_rate = v;
	endtask

	initial begin : run_test
		request_t         rq;
		logic [TPS_W-1:0] phase_rate [6];
		phase_rate = '{14'd1, 14'd10000, 14'd1000, 14'd2, 14'd37, 14'd1};
		phase_rate[2] = TPS_W'($urandom_range(1, 10000));
		phase_rate[4] = TPS_W'($urandom_range(1, 50));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset tick rate: zero delay, single release, no release, extremes, h:m:s checks
		add_request(MODE_MS, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_MS, 4'd1, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_TICK, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_TICK, 4'd15, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_request(MODE_MS, 4'd15, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_S, 4'd14, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_S, 4'd14, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd2, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd2, 32'd0, 8'd0, 8'd60, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd2, 32'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		add_request(MODE_HMS, 4'd2, 32'd0, 8'd0, 8'd59, 8'd60, 1'b0);
		add_request(MODE_HMS, 4'd2, 32'd0, 8'd255, 8'd59, 8'd59, 1'b0);
		// three slots blocked, one re-blocked shorter to become the newest and expire first, the other two together
		add_request(MODE_MS, 4'd3, 32'd2, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_MS, 4'd5, 32'd2, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_MS, 4'd7, 32'd2, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_MS, 4'd5, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_TICK, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		add_request(MODE_TICK, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd4, 32'd0, 8'd0, 8'd0, 8'd1, 1'b0);
		wait_idle();

		// Slowest tick rate: sub-tick ms delay, short s and h:m:s delays
		set_rate(14'd1);
		add_request(MODE_MS, 4'd6, 32'd999, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_S, 4'd6, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd8, 32'd0, 8'd0, 8'd0, 8'd2, 1'b0);
		add_request(MODE_TICK, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_TICK, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		wait_idle();

		// Fastest tick rate: saturation of s and h:m:s conversions
		set_rate(14'd10000);
		add_request(MODE_S, 4'd9, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd10, 32'd0, 8'd255, 8'd59, 8'd59, 1'b0);
		add_request(MODE_MS, 4'd11, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		wait_idle();

		// Zero tick rate: every valid delay converts to zero ticks
		set_rate(14'd0);
		add_request(MODE_MS, 4'd12, 32'd5000, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_S, 4'd12, 32'd7, 8'd0, 8'd0, 8'd0, 1'b0);
		add_request(MODE_HMS, 4'd13, 32'd0, 8'd1, 8'd2, 8'd3, 1'b0);

		// Random phases, one under a long receiver hold-off; in two of them the first requests have no sender gaps
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			set_rate(phase_rate[p]);
			if (p == 2)
				hold_req = 1'b1;
			for (int k = 0; k < 43; k++) begin
				rq = rand_request(int'(phase_rate[p]));
				if ((p == 2 && k < 30) || (p == 5 && k < 25)) begin
					rq.gap = 0;
					rq.wait_drain = 1'b0;
				end
				pending_requests.push_back(rq);
			end
		end
		wait_idle();
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("task_delay_timer_table_top verification clean");
		else
			$display("task_delay_timer_table_top verification failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("task_delay_timer_table_top verification failed");
		$finish;
	end

endmodule
